### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and the two-byte glyph table of the text console.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // default geometry and table size
  localparam int unsigned COLUMNS_DEF      = 80;
  localparam int unsigned ROWS_DEF         = 25;
  localparam int unsigned TAB_WIDTH_DEF    = 8;
  localparam int unsigned PAIR_ENTRIES_DEF = 41;

  // blank word loaded at reset: light grey on black, space
  localparam logic [15:0] BLANK_RESET = 16'h0720;

  // byte codes
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] LEAD_MIN     = 8'h7f;
  localparam logic [7:0] GLYPH_BASE   = 8'h80;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_GREAD,
    ST_GWRITE,
    ST_SCROLL,
    ST_FILL,
    ST_RREAD,
    ST_RDATA,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       hit;
    logic [6:0] idx;
  } pair_hit_t;

  localparam int unsigned TABLE_SIZE = 41;

  // lead byte in the high half, trailing byte in the low half
  localparam logic [15:0] PAIR_TABLE [TABLE_SIZE] = '{
    16'hC387, 16'hC3BC, 16'hC3A9, 16'hC3A2,
    16'hC3A4, 16'hC3A0, 16'hC3A5, 16'hC3A7,
    16'hC3AA, 16'hC3AB, 16'hC3A8, 16'hC3AF,
    16'hC3AE, 16'hC3AC, 16'hC384, 16'hC385,
    16'hC389, 16'hC3A6, 16'hC386, 16'hC3B4,
    16'hC3B6, 16'hC3B2, 16'hC3BB, 16'hC3B9,
    16'hC3BF, 16'hC396, 16'hC39C, 16'hC2A2,
    16'hE282, 16'hC2A5, 16'hE282, 16'hC692,
    16'hC3A1, 16'hC3AD, 16'hC3B3, 16'hC3BA,
    16'hC3B1, 16'hC391, 16'hC2AA, 16'hC2B0,
    16'hC2BF
  };

  // priority match over the first n entries, lowest index wins
  function automatic pair_hit_t pair_lookup(logic [7:0] lead, logic [7:0] trail,
                                            int unsigned n);
    pair_hit_t r;
    r = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < n && PAIR_TABLE[i] == {lead, trail}) begin
        r.hit = 1'b1;
        r.idx = 7'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cell store, cursor, control bytes and two-byte glyphs.
// ----------------------------------------------------------------------------
// One request is taken at a time and the block drops in_ready_o while it
// works. A control byte, a lead byte, an unmatched pair or an unused kind
// goes straight to its result; a printable byte or a matched pair first
// reads the cursor cell for its attribute, then writes the character; a cell
// read reads the store, then registers the word. A row scroll and a clear
// both go through the single write port of the cell store, which moves one
// cell per cycle. After reset a clearing pass over all COLUMNS*ROWS cells
// fills the store with 0x0720 before the first request is taken; cfg_we_i
// writes of the blank word are taken during it. A finished result sits in
// the output register until taken, and the next request is accepted
// meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int unsigned COLUMNS      = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS         = tcw_pkg::ROWS_DEF,
  parameter int unsigned TAB_WIDTH    = tcw_pkg::TAB_WIDTH_DEF,
  parameter int unsigned PAIR_ENTRIES = tcw_pkg::PAIR_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [10:0] cell_index_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [6:0]       cursor_col_o,
  output logic [4:0]       cursor_row_o,
  output logic [10:0]      cursor_linear_o,
  output logic [15:0]      cell_word_o,
  output logic             lead_pending_o
);

  localparam int unsigned CELLS       = COLUMNS * ROWS;
  localparam int unsigned SHIFT_CELLS = COLUMNS * (ROWS - 1);
  localparam int unsigned ADDR_W      = $clog2(CELLS);
  localparam int unsigned CNT_W       = $clog2(CELLS + 1);
  localparam int unsigned COL_W       = $clog2(COLUMNS);
  localparam int unsigned ROW_W       = $clog2(ROWS);
  localparam int unsigned TAB_STEPS   = COLUMNS / TAB_WIDTH + 1;

  // next tab stop strictly right of col
  function automatic int unsigned tab_stop(logic [COL_W-1:0] col);
    int unsigned nc;
    nc = 0;
    for (int unsigned m = TAB_STEPS; m >= 1; m--) begin
      if (m * TAB_WIDTH > 32'(col)) begin
        nc = m * TAB_WIDTH;
      end
    end
    return nc;
  endfunction

  tcw_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;       // shared sweep counter
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [7:0]       lead_q, lead_d;
  logic [15:0]      blank_q;

  // latched request
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic [10:0] idx_q;
  logic [7:0]  glyph_q, glyph_d;
  logic [15:0] word_q, word_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [6:0]  out_col_q;
  logic [4:0]  out_row_q;
  logic [10:0] out_lin_q;
  logic [15:0] out_word_q;
  logic        out_lead_q;

  // cell store ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic [31:0]       lin32;
  logic [31:0]       cnt32;
  logic [31:0]       src32;
  logic [31:0]       prev32;
  logic [31:0]       col32;
  logic [31:0]       row32;
  int unsigned       nc;
  logic              go_next_row;
  tcw_pkg::pair_hit_t ph;

  assign in_ready_o = (state_q == tcw_pkg::ST_IDLE);

  // linear cursor position, also the store address of the cursor cell
  assign col32  = 32'(col_q);
  assign row32  = 32'(row_q);
  assign lin32  = row32 * COLUMNS + col32;
  assign cnt32  = 32'(cnt_q);
  assign src32  = cnt32 + COLUMNS;
  assign prev32 = cnt32 - 32'd1;

  assign ph = tcw_pkg::pair_lookup(lead_q, byte_q, PAIR_ENTRIES);
  assign nc = tab_stop(col_q);

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    lead_d      = lead_q;
    glyph_d     = glyph_q;
    word_d      = word_q;
    out_load    = 1'b0;
    go_next_row = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[ADDR_W-1:0];
    ram_wdata   = blank_q;
    ram_raddr   = lin32[ADDR_W-1:0];

    case (state_q)
      // clearing pass after reset, uses the reset blank word
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::BLANK_RESET;
        if (cnt32 == CELLS - 1) begin
          cnt_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      tcw_pkg::ST_IDLE: begin
        word_d = '0;
        if (in_valid_i) begin
          state_d = tcw_pkg::ST_EXEC;
        end
      end

      tcw_pkg::ST_EXEC: begin
        state_d = tcw_pkg::ST_DONE;
        case (kind_q)
          tcw_pkg::KIND_PUT: begin
            if (byte_q == tcw_pkg::CH_NEWLINE) begin
              go_next_row = 1'b1;
            end else if (byte_q == tcw_pkg::CH_TAB) begin
              if (nc >= COLUMNS) begin
                go_next_row = 1'b1;
              end else begin
                col_d = COL_W'(nc);
              end
            end else if (byte_q == tcw_pkg::CH_BACKSPACE) begin
              // non-erasing, wraps to the end of the row above (of row 0 when at the top)
              if (col_q == '0) begin
                col_d = COL_W'(COLUMNS - 1);
                if (row_q != '0) begin
                  row_d = row_q - ROW_W'(1);
                end
              end else begin
                col_d = col_q - COL_W'(1);
              end
            end else if (byte_q >= tcw_pkg::LEAD_MIN) begin
              if (lead_q != '0) begin
                // lead is dropped whether or not the pair matches
                lead_d = '0;
                if (ph.hit) begin
                  glyph_d = 8'(32'(tcw_pkg::GLYPH_BASE) + 32'(ph.idx));
                  state_d = tcw_pkg::ST_GREAD;
                end
              end else begin
                lead_d = byte_q;
              end
            end else begin
              glyph_d = byte_q;
              state_d = tcw_pkg::ST_GREAD;
            end
          end
          tcw_pkg::KIND_READ: begin
            if (32'(idx_q) < CELLS) begin
              state_d = tcw_pkg::ST_RREAD;
            end
          end
          tcw_pkg::KIND_CLEAR: begin
            cnt_d   = '0;
            col_d   = '0;
            row_d   = '0;
            state_d = tcw_pkg::ST_CLEAR;
          end
          default: begin
            state_d = tcw_pkg::ST_DONE;
          end
        endcase
      end

      // fetch the cursor cell so its attribute byte is kept
      tcw_pkg::ST_GREAD: begin
        state_d = tcw_pkg::ST_GWRITE;
      end

      tcw_pkg::ST_GWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = lin32[ADDR_W-1:0];
        ram_wdata = {ram_rdata[15:8], glyph_q};
        state_d   = tcw_pkg::ST_DONE;
        if (col32 + 32'd1 >= COLUMNS) begin
          go_next_row = 1'b1;
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end

      // move rows up: read one row ahead, write the cell read last cycle
      tcw_pkg::ST_SCROLL: begin
        ram_raddr = src32[ADDR_W-1:0];
        ram_we    = (cnt_q != '0);
        ram_waddr = prev32[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (cnt32 == SHIFT_CELLS) begin
          state_d = tcw_pkg::ST_FILL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      // blank the new bottom row
      tcw_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (cnt32 == CELLS - 1) begin
          state_d = tcw_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      tcw_pkg::ST_RREAD: begin
        ram_raddr = ADDR_W'(idx_q);
        state_d   = tcw_pkg::ST_RDATA;
      end

      tcw_pkg::ST_RDATA: begin
        word_d  = ram_rdata;
        state_d = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt32 == CELLS - 1) begin
          state_d = tcw_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end

      tcw_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase

    // newline, tab past the end or glyph in the last column
    if (go_next_row) begin
      col_d = '0;
      if (row32 + 32'd1 < ROWS) begin
        row_d = row_q + ROW_W'(1);
      end else begin
        cnt_d   = '0;
        state_d = tcw_pkg::ST_SCROLL;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      lead_q      <= '0;
      blank_q     <= tcw_pkg::BLANK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        blank_q <= cfg_wdata_i;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    word_q  <= word_d;
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      byte_q <= data_byte_i;
      idx_q  <= cell_index_i;
    end
    if (out_load) begin
      out_col_q  <= col32[6:0];
      out_row_q  <= row32[4:0];
      out_lin_q  <= lin32[10:0];
      out_word_q <= word_q;
      out_lead_q <= (lead_q != '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_linear_o = out_lin_q;
  assign cell_word_o     = out_word_q;
  assign lead_pending_o  = out_lead_q;

endmodule

`default_nettype wire
